// ----- rtl/core/marked_mesh_area_accumulator_defines.svh -----
// Assertion macros for the marked mesh area accumulator
`ifndef MARKED_MESH_AREA_ACCUMULATOR_DEFINES_SVH
`define MARKED_MESH_AREA_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTH
`define MMA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MMA_ASSERT(label, clk, rst_n, prop, msg)
`define MMA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/core/mma_pkg.sv -----
`default_nettype none
package mma_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int SCALE_WIDTH     = 24;
    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd65536;
    localparam int ROOT_WIDTH      = 64;
    localparam int RAD_WIDTH       = 128;
    localparam logic [0:0] REG_MODEL_SCALE = 1'b0;

    typedef struct packed {
        logic        selected;
        logic        final_tri;
    } tri_ctrl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_CROSS,
        BK_SQUARE,
        BK_ROOT,
        BK_SCALE,
        BK_SCALE2,
        BK_OUT
    } back_state_t;
endpackage
`default_nettype wire

// ----- rtl/core/mma_if.sv -----
`default_nettype none
interface mma_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] corner_a_x;
    logic [31:0] corner_a_y;
    logic [31:0] corner_a_z;
    logic [31:0] corner_b_x;
    logic [31:0] corner_b_y;
    logic [31:0] corner_b_z;
    logic [31:0] corner_c_x;
    logic [31:0] corner_c_y;
    logic [31:0] corner_c_z;
    logic [2:0]  corners_selected;
    logic        final_triangle;
    modport source (output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                    corner_b_z, corner_c_x, corner_c_y, corner_c_z, corners_selected,
                    final_triangle, input ready);
    modport sink (input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                  corner_b_z, corner_c_x, corner_c_y, corner_c_z, corners_selected,
                  final_triangle, output ready);
endinterface

interface mma_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] selected_area;
    logic [31:0] summed_triangles;
    modport source (output valid, selected_area, summed_triangles, input ready);
    modport sink (input valid, selected_area, summed_triangles, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mma_front.sv -----
`default_nettype none
// Accepts triangles, forms edges, classifies, pushes into a two-entry queue.
module mma_front #(
    parameter int COORD_WIDTH = mma_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mma_in_if.sink    in_req,
    output logic      q_valid,
    input  wire logic q_pop,
    output logic [COORD_WIDTH:0] q_ux,
    output logic [COORD_WIDTH:0] q_uy,
    output logic [COORD_WIDTH:0] q_uz,
    output logic [COORD_WIDTH:0] q_vx,
    output logic [COORD_WIDTH:0] q_vy,
    output logic [COORD_WIDTH:0] q_vz,
    output mma_pkg::tri_ctrl_t   q_ctrl
);
    import mma_pkg::*;
    localparam int EW = COORD_WIDTH + 1;
    typedef struct packed {
        logic [EW-1:0] ux, uy, uz, vx, vy, vz;
        tri_ctrl_t     ctrl;
    } entry_t;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    entry_t     push_entry;
    logic       push;

    function automatic logic [EW-1:0] sx(input logic [31:0] raw);
        return {raw[COORD_WIDTH-1], raw[COORD_WIDTH-1:0]};
    endfunction

    always_comb
    begin
        push_entry.ux = sx(in_req.corner_b_x) - sx(in_req.corner_a_x);
        push_entry.uy = sx(in_req.corner_b_y) - sx(in_req.corner_a_y);
        push_entry.uz = sx(in_req.corner_b_z) - sx(in_req.corner_a_z);
        push_entry.vx = sx(in_req.corner_c_x) - sx(in_req.corner_a_x);
        push_entry.vy = sx(in_req.corner_c_y) - sx(in_req.corner_a_y);
        push_entry.vz = sx(in_req.corner_c_z) - sx(in_req.corner_a_z);
        push_entry.ctrl.selected  = (in_req.corners_selected == 3'b111);
        push_entry.ctrl.final_tri = in_req.final_triangle;
    end

    assign in_req.ready = (cnt_reg != 2'd2);
    assign push = in_req.valid && in_req.ready;
    assign q_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    assign q_ux = mem_reg[rd_ptr_reg].ux;
    assign q_uy = mem_reg[rd_ptr_reg].uy;
    assign q_uz = mem_reg[rd_ptr_reg].uz;
    assign q_vx = mem_reg[rd_ptr_reg].vx;
    assign q_vy = mem_reg[rd_ptr_reg].vy;
    assign q_vz = mem_reg[rd_ptr_reg].vz;
    assign q_ctrl = mem_reg[rd_ptr_reg].ctrl;
endmodule
`default_nettype wire

// ----- rtl/core/mma_back.sv -----
`default_nettype none
// Cross product, squared length, bit-serial root, accumulate, scale.
module mma_back #(
    parameter int COORD_WIDTH = mma_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic      q_pop,
    input  wire logic [COORD_WIDTH:0] q_ux,
    input  wire logic [COORD_WIDTH:0] q_uy,
    input  wire logic [COORD_WIDTH:0] q_uz,
    input  wire logic [COORD_WIDTH:0] q_vx,
    input  wire logic [COORD_WIDTH:0] q_vy,
    input  wire logic [COORD_WIDTH:0] q_vz,
    input  mma_pkg::tri_ctrl_t        q_ctrl,
    input  wire logic [mma_pkg::SCALE_WIDTH-1:0] model_scale,
    mma_out_if.source out_req
);
    import mma_pkg::*;
    `include "marked_mesh_area_accumulator_defines.svh"
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int SW = 2 * CW + 2;
    localparam int LW = CW - CW / 2;

    back_state_t state_reg, state_next;
    logic signed [EW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PW-1:0] p_reg [6];
    logic signed [CW-1:0] c_reg [3];
    logic [1:0]   idx_reg, idx_next;
    logic [1:0]   step_reg, step_next;
    logic [SW-1:0] sq_sum_reg;
    logic [RAD_WIDTH-1:0] rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [6:0]   bit_reg;
    logic         final_reg;
    logic [63:0]  area_sum_reg;
    logic [31:0]  count_reg;
    logic [47:0]  s2_reg;
    logic [1:0]   part_reg;
    logic [111:0] prod_reg;
    logic         out_valid_reg;
    logic [63:0]  out_area_reg;
    logic [31:0]  out_cnt_reg;
    logic [CW-1:0] c_abs;
    logic [LW-1:0] mul_a, mul_b;
    logic [2*LW-1:0] sq_part;
    logic [SW-1:0] sq_term;
    logic [RAD_WIDTH+1:0] trial;
    logic [ROOT_WIDTH-1:0] root_step;
    logic [64:0]  acc_sum;
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mul_xy;
    logic [111:0] partial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        idx_next = idx_reg;
        step_next = step_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    idx_next = 2'd0;
                    step_next = 2'd0;
                    if (q_ctrl.selected)
                        state_next = BK_PROD;
                    else if (q_ctrl.final_tri)
                        state_next = BK_SCALE;
                end
            end
            BK_PROD:   state_next = BK_CROSS;
            BK_CROSS:  state_next = BK_SQUARE;
            BK_SQUARE:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    step_next = 2'd0;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd2)
                        state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (bit_reg == 7'd0)
                    state_next = final_reg ? BK_SCALE : BK_IDLE;
            end
            BK_SCALE:  state_next = BK_SCALE2;
            BK_SCALE2:
            begin
                if (part_reg == 2'd3)
                    state_next = BK_OUT;
            end
            BK_OUT:    state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    assign c_abs = c_reg[idx_reg][CW-1] ? CW'(-c_reg[idx_reg]) : CW'(c_reg[idx_reg]);

    // square as lo*lo, then 2*lo*hi, then hi*hi
    always_comb
    begin
        case (step_reg)
            2'd1:
            begin
                mul_a = c_abs[LW-1:0];
                mul_b = LW'(c_abs[CW-1:LW]);
            end
            2'd2:
            begin
                mul_a = LW'(c_abs[CW-1:LW]);
                mul_b = LW'(c_abs[CW-1:LW]);
            end
            default:
            begin
                mul_a = c_abs[LW-1:0];
                mul_b = c_abs[LW-1:0];
            end
        endcase
    end

    assign sq_part = mul_a * mul_b;
    assign sq_term = (step_reg == 2'd2) ? (SW'(sq_part) << (2 * LW))
                   : (step_reg == 2'd1) ? (SW'(sq_part) << (LW + 1))
                                        : SW'(sq_part);
    assign trial = {2'b0, rem_reg}
                   - ({{(RAD_WIDTH - ROOT_WIDTH + 2){1'b0}}, root_reg}
                      << (bit_reg[5:0] + 7'd1))
                   - ({2'b0, {{(RAD_WIDTH-1){1'b0}}, 1'b1}} << {bit_reg[5:0], 1'b0});
    assign root_step = trial[RAD_WIDTH+1] ? root_reg
                                          : (root_reg | (ROOT_WIDTH'(1) << bit_reg[5:0]));
    assign acc_sum = {1'b0, area_sum_reg} + {1'b0, root_step};
    assign mul_x = part_reg[1] ? area_sum_reg[63:32] : area_sum_reg[31:0];
    assign mul_y = part_reg[0] ? {16'd0, s2_reg[47:32]} : s2_reg[31:0];
    assign mul_xy = mul_x * mul_y;
    assign partial = {48'd0, mul_xy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_sum_reg  <= 64'd0;
            count_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_req.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                BK_IDLE:
                begin
                    if (q_pop && q_ctrl.selected && count_reg != 32'hFFFF_FFFF)
                        count_reg <= count_reg + 32'd1;
                end
                BK_ROOT:
                begin
                    if (bit_reg == 7'd0)
                        area_sum_reg <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : acc_sum[63:0];
                end
                BK_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_area_reg  <= (prod_reg[111:97] != 15'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                                 : prod_reg[96:33];
                    out_cnt_reg   <= count_reg;
                    area_sum_reg  <= 64'd0;
                    count_reg     <= 32'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            step_reg <= 2'd0;
        end
        else
        begin
            idx_reg  <= idx_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (q_pop)
                begin
                    ux_reg <= q_ux; uy_reg <= q_uy; uz_reg <= q_uz;
                    vx_reg <= q_vx; vy_reg <= q_vy; vz_reg <= q_vz;
                    final_reg <= q_ctrl.final_tri;
                end
            end
            BK_PROD:
            begin
                p_reg[0] <= uy_reg * vz_reg; p_reg[1] <= uz_reg * vy_reg;
                p_reg[2] <= uz_reg * vx_reg; p_reg[3] <= ux_reg * vz_reg;
                p_reg[4] <= ux_reg * vy_reg; p_reg[5] <= uy_reg * vx_reg;
                sq_sum_reg <= '0;
            end
            BK_CROSS:
            begin
                c_reg[0] <= CW'(p_reg[0]) - CW'(p_reg[1]);
                c_reg[1] <= CW'(p_reg[2]) - CW'(p_reg[3]);
                c_reg[2] <= CW'(p_reg[4]) - CW'(p_reg[5]);
            end
            BK_SQUARE:
            begin
                sq_sum_reg <= sq_sum_reg + sq_term;
                root_reg <= '0;
                bit_reg  <= 7'd63;
                if (idx_reg == 2'd2 && step_reg == 2'd2)
                    rem_reg <= RAD_WIDTH'(({2'b0, sq_sum_reg + sq_term}) >> 32);
            end
            BK_ROOT:
            begin
                if (!trial[RAD_WIDTH+1])
                begin
                    rem_reg  <= trial[RAD_WIDTH-1:0];
                    root_reg <= root_step;
                end
                bit_reg <= bit_reg - 7'd1;
            end
            BK_SCALE:
            begin
                s2_reg   <= model_scale * model_scale;
                part_reg <= 2'd0;
                prod_reg <= '0;
            end
            BK_SCALE2:
            begin
                case (part_reg)
                    2'd0:       prod_reg <= prod_reg + partial;
                    2'd1, 2'd2: prod_reg <= prod_reg + (partial << 32);
                    default:    prod_reg <= prod_reg + (partial << 64);
                endcase
                part_reg <= part_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign out_req.valid = out_valid_reg;
    assign out_req.selected_area = out_area_reg;
    assign out_req.summed_triangles = out_cnt_reg;

    `MMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_req.ready, out_valid_reg, "result dropped")
    `MMA_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> (state_reg == BK_IDLE && q_valid), "pop outside idle")
    `MMA_ASSERT(a_out_state, clk, rst_n, (state_reg == BK_OUT) |-> !out_valid_reg, "result overwritten")
endmodule
`default_nettype wire

// ----- rtl/core/marked_mesh_area_accumulator.sv -----
`default_nettype none
// channel | dir | payload
// in_req  | in  | corners a,b,c xyz, corners_selected, final_triangle
// out_req | out | selected_area, summed_triangles
// apb     | in  | model_scale at 0x0
// Selected triangle: a 9-step squaring, then the bit-serial square root (64 steps).
// A final triangle adds the scale product. Two-entry queue between front and back; a
// waiting result stalls the back, and the input once the queue fills.
// Reset is asynchronous, active low; no clearing pass.
module marked_mesh_area_accumulator #(
    parameter int COORD_WIDTH = mma_pkg::COORD_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mma_in_if.sink           in_req,
    mma_out_if.source        out_req,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mma_pkg::*;
    logic [SCALE_WIDTH-1:0] scale_reg;
    logic q_valid, q_pop;
    logic [COORD_WIDTH:0] ux, uy, uz, vx, vy, vz;
    tri_ctrl_t q_ctrl;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {REG_MODEL_SCALE, 1'b0}) ? {8'd0, scale_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (psel && penable && pwrite && paddr == {REG_MODEL_SCALE, 1'b0})
            scale_reg <= pwdata[SCALE_WIDTH-1:0];
    end

    mma_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop),
        .q_ux(ux), .q_uy(uy), .q_uz(uz), .q_vx(vx), .q_vy(vy), .q_vz(vz), .q_ctrl(q_ctrl)
    );

    mma_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_ux(ux), .q_uy(uy), .q_uz(uz), .q_vx(vx), .q_vy(vy), .q_vz(vz), .q_ctrl(q_ctrl),
        .model_scale(scale_reg), .out_req(out_req)
    );
endmodule
`default_nettype wire

// ----- verif/tb_marked_mesh_area_accumulator.sv -----
`default_nettype none
module tb_marked_mesh_area_accumulator;
    import mma_pkg::*;

    typedef struct {
        logic [31:0] crd [9];
        logic [2:0]  sel;
        logic        fin;
        logic        typed;
        logic [63:0] typed_area;
        logic [31:0] typed_count;
    } tri_row_t;

    typedef struct {
        logic [63:0] area;
        logic [31:0] count;
    } area_rec_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_CYCLES    = 2000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mma_in_if  in_req ();
    mma_out_if out_req ();

    marked_mesh_area_accumulator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req),
        .out_req (out_req),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [23:0] scale_reg;
    logic [63:0] running_area;
    logic [31:0] running_count;
    area_rec_t   pending_areas [$];
    tri_row_t    cur_row;
    int          errors;
    int          src_idle;
    int          snk_idle;
    logic        hold_req;
    int          idle_cycles;
    int          results_seen;
    int          tris_sent;
    int          scales_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] cross_length(tri_row_t r);
        logic signed [32:0]  ux, uy, uz, vx, vy, vz;
        logic signed [66:0]  cx, cy, cz;
        logic signed [135:0] sq;
        logic [127:0]        rad, t2;
        logic [63:0]         root, t;
        ux = $signed({r.crd[3][31], r.crd[3]}) - $signed({r.crd[0][31], r.crd[0]});
        uy = $signed({r.crd[4][31], r.crd[4]}) - $signed({r.crd[1][31], r.crd[1]});
        uz = $signed({r.crd[5][31], r.crd[5]}) - $signed({r.crd[2][31], r.crd[2]});
        vx = $signed({r.crd[6][31], r.crd[6]}) - $signed({r.crd[0][31], r.crd[0]});
        vy = $signed({r.crd[7][31], r.crd[7]}) - $signed({r.crd[1][31], r.crd[1]});
        vz = $signed({r.crd[8][31], r.crd[8]}) - $signed({r.crd[2][31], r.crd[2]});
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        sq = cx * cx + cy * cy + cz * cz;
        rad = 128'(sq[135:32]);
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            t2 = 128'(t) * 128'(t);
            if (t2 <= rad)
                root = t;
        end
        return root;
    endfunction

    // returns 1 when the triangle closes a mesh
    function automatic bit accumulate_triangle(tri_row_t r, output area_rec_t res);
        logic [63:0]  root;
        logic [47:0]  s2;
        logic [111:0] prod;
        res.area = '0;
        res.count = '0;
        if (r.sel == 3'b111)
        begin
            root = cross_length(r);
            running_area = (running_area > ~root) ? '1 : running_area + root;
            if (running_count != '1)
                running_count++;
        end
        if (!r.fin)
            return 0;
        s2 = 48'(scale_reg) * 48'(scale_reg);
        prod = 112'(running_area) * 112'(s2);
        res.area = (prod[111:97] != 0) ? '1 : prod[96:33];
        res.count = running_count;
        running_area = '0;
        running_count = '0;
        return 1;
    endfunction

    always @(posedge clk)
    begin
        area_rec_t got, want, pred;
        bit        busy;
        busy = 1'b0;
        if (rst_n && in_req.valid && in_req.ready)
        begin
            busy = 1'b1;
            tris_sent++;
            if (accumulate_triangle(cur_row, pred))
            begin
                if (cur_row.typed)
                begin
                    pred.area = cur_row.typed_area;
                    pred.count = cur_row.typed_count;
                end
                pending_areas.push_back(pred);
            end
        end
        if (rst_n && out_req.valid && out_req.ready)
        begin
            busy = 1'b1;
            results_seen++;
            got.area = out_req.selected_area;
            got.count = out_req.summed_triangles;
            if (pending_areas.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result area=%h count=%0d", $time, got.area,
                         got.count);
            end
            else
            begin
                want = pending_areas.pop_front();
                if (got.area !== want.area)
                begin
                    errors++;
                    $display("%0t: selected_area expected %h actual %h", $time, want.area,
                             got.area);
                end
                if (got.count !== want.count)
                begin
                    errors++;
                    $display("%0t: summed_triangles expected %0d actual %0d", $time,
                             want.count, got.count);
                end
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, %0d results outstanding", $time, pending_areas.size());
            $display("tb_marked_mesh_area_accumulator: FAIL");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        out_req.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_req.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_req.ready = ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic apb_write(input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 2'(REG_MODEL_SCALE * 4);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        scale_reg = value[23:0];
        scales_used++;
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[23:0] !== scale_reg)
        begin
            errors++;
            $display("%0t: model_scale readback expected %h actual %h", $time, scale_reg,
                     prdata[23:0]);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain_results();
        in_req.valid = 1'b0;
        while (pending_areas.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_triangle(input tri_row_t r);
        int gap;
        if ($urandom_range(99) < src_idle)
        begin
            in_req.valid = 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(negedge clk);
        end
        cur_row = r;
        in_req.corner_a_x = r.crd[0];
        in_req.corner_a_y = r.crd[1];
        in_req.corner_a_z = r.crd[2];
        in_req.corner_b_x = r.crd[3];
        in_req.corner_b_y = r.crd[4];
        in_req.corner_b_z = r.crd[5];
        in_req.corner_c_x = r.crd[6];
        in_req.corner_c_y = r.crd[7];
        in_req.corner_c_z = r.crd[8];
        in_req.corners_selected = r.sel;
        in_req.final_triangle = r.fin;
        in_req.valid = 1'b1;
        do @(posedge clk); while (!in_req.ready);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
            3:       return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(20 * ONE)) - 10 * ONE);
        endcase
    endfunction

    function automatic tri_row_t rand_triangle(int fin_pct);
        tri_row_t r;
        foreach (r.crd[i])
            r.crd[i] = rand_coord();
        r.sel = ($urandom_range(99) < 75) ? 3'b111 : 3'($urandom_range(7));
        r.fin = ($urandom_range(99) < fin_pct);
        r.typed = 1'b0;
        r.typed_area = '0;
        r.typed_count = '0;
        return r;
    endfunction

    function automatic tri_row_t mk_row(logic [31:0] a, logic [31:0] b, logic [2:0] sel,
                                        logic fin);
        tri_row_t r;
        foreach (r.crd[i])
            r.crd[i] = (i % 2 == 0) ? a : b;
        r.sel = sel;
        r.fin = fin;
        r.typed = 1'b0;
        r.typed_area = '0;
        r.typed_count = '0;
        return r;
    endfunction

    tri_row_t directed_rows [$];

    task automatic build_directed();
        tri_row_t r;
        r = mk_row('0, '0, 3'b000, 1'b1);
        r.typed = 1'b1;
        directed_rows.push_back(r);
        r = mk_row('0, '0, 3'b111, 1'b0);
        r.crd[3] = ONE;
        r.crd[7] = ONE;
        directed_rows.push_back(r);
        r.fin = 1'b1;
        r.typed = 1'b1;
        r.typed_area = 64'd65536;
        r.typed_count = 32'd2;
        directed_rows.push_back(r);
        r.sel = 3'b011;
        r.typed_area = '0;
        r.typed_count = '0;
        directed_rows.push_back(r);
        for (int s = 0; s < 7; s++)
            directed_rows.push_back(mk_row(32'h7fff_ffff, 32'h8000_0000, 3'(s), 1'b0));
        directed_rows.push_back(mk_row(32'h7fff_ffff, 32'h8000_0000, 3'b111, 1'b0));
        r = mk_row(32'h8000_0000, 32'h8000_0000, 3'b111, 1'b0);
        r.crd[3] = 32'h7fff_ffff;
        r.crd[7] = 32'h7fff_ffff;
        r.crd[5] = 32'h7fff_ffff;
        directed_rows.push_back(r);
        r.crd[0] = 32'h7fff_ffff;
        r.crd[4] = 32'h8000_0000;
        directed_rows.push_back(r);
        directed_rows.push_back(mk_row(32'hffff_ffff, 32'h0000_0001, 3'b111, 1'b1));
        r = mk_row(32'h0000_0001, 32'hffff_ffff, 3'b111, 1'b1);
        r.crd[3] = 32'h0000_0002;
        r.crd[7] = 32'h0000_0003;
        directed_rows.push_back(r);
    endtask

    initial
    begin
        tri_row_t r;
        int       n;
        errors = 0;
        results_seen = 0;
        tris_sent = 0;
        scales_used = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        src_idle = 0;
        snk_idle = 0;
        scale_reg = SCALE_RESET;
        running_area = '0;
        running_count = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_row = mk_row('0, '0, '0, '0);
        in_req.valid = 1'b0;
        in_req.corner_a_x = '0;
        in_req.corner_a_y = '0;
        in_req.corner_a_z = '0;
        in_req.corner_b_x = '0;
        in_req.corner_b_y = '0;
        in_req.corner_b_z = '0;
        in_req.corner_c_x = '0;
        in_req.corner_c_y = '0;
        in_req.corner_c_z = '0;
        in_req.corners_selected = '0;
        in_req.final_triangle = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset scale first, then extremes of the register
        build_directed();
        foreach (directed_rows[i])
            send_triangle(directed_rows[i]);
        drain_results();
        apb_write(32'h00ff_ffff);
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            r.typed = 1'b0;
            send_triangle(r);
        end
        drain_results();
        apb_write(32'h0000_0000);
        send_triangle(rand_triangle(0));
        send_triangle(mk_row('0, '0, 3'b111, 1'b1));
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
            snk_idle = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
            apb_write((phase == 2) ? 32'(SCALE_RESET) : 32'($urandom_range(24'hff_ffff)));
            if (phase == 0)
                hold_req = 1'b1;
            n = 0;
            while (n < RANDOM_ITEMS / 3)
            begin
                r = rand_triangle(15);
                n++;
                send_triangle(r);
            end
            send_triangle(mk_row('0, '0, 3'b000, 1'b1));
            drain_results();
        end

        $display("Sent %0d triangles under %0d scale settings, checked %0d mesh results.",
                 tris_sent, scales_used + 1, results_seen);
        if (errors == 0)
            $display("tb_marked_mesh_area_accumulator: PASS");
        else
            $display("tb_marked_mesh_area_accumulator: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mma_pkg.sv
rtl/core/mma_if.sv
rtl/core/mma_front.sv
rtl/core/mma_back.sv
rtl/core/marked_mesh_area_accumulator.sv
verif/tb_marked_mesh_area_accumulator.sv
